### design/eor_pkg.sv
// shared types, constants and state codes of the ellipse outline rasterizer
package eor_pkg;

	// radius bound and result limit of one command
	localparam int MAX_RADIUS  = 15;
	localparam int MAX_RESULTS = 47;

	// field widths
	localparam int POS_W = 6;
	localparam int RAD_W = 4;
	localparam int VAL_W = 8;
	localparam int PT_W  = 8;
	localparam int ACC_W = 24;
	localparam int CNT_W = 6;

	localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

	// point masks
	localparam logic [3:0] MASK_MAIN = 4'd15;
	localparam logic [3:0] MASK_TIP  = 4'd3;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_INIT,
		ST_MAIN,
		ST_TIP
	} state_t;

	// draw command payload
	typedef struct packed {
		logic [POS_W-1:0] center_x;
		logic [POS_W-1:0] center_y;
		logic [RAD_W-1:0] radius_x;
		logic [RAD_W-1:0] radius_y;
		logic [VAL_W-1:0] pixel_value;
	} cmd_t;

	// point group payload
	typedef struct packed {
		logic signed [PT_W-1:0] px0;
		logic signed [PT_W-1:0] py0;
		logic signed [PT_W-1:0] px1;
		logic signed [PT_W-1:0] py1;
		logic signed [PT_W-1:0] px2;
		logic signed [PT_W-1:0] py2;
		logic signed [PT_W-1:0] px3;
		logic signed [PT_W-1:0] py3;
		logic [3:0]             point_mask;
		logic [VAL_W-1:0]       point_value;
		logic                   last;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic square;
		logic init;
		logic step_main;
		logic step_tip;
		logic last;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic main_more;
		logic tip_after_main;
		logic tip_more;
	} dp_status_t;

endpackage

### design/eor_cmd_if.sv
// draw command channel
interface eor_cmd_if;
	logic          valid;
	logic          ready;
	eor_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/eor_pt_if.sv
// point group channel
interface eor_pt_if;
	logic             valid;
	logic             ready;
	eor_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/eor_dp.sv
// datapath: held command, error-term walk, point generation and output register
module eor_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  eor_pkg::cmd_t       cmd_data,
	input  eor_pkg::dp_cmd_t    ctl,
	output eor_pkg::dp_status_t status,
	output eor_pkg::result_t    out_data
);
	import eor_pkg::*;

	logic [POS_W-1:0]        cx_q, cy_q;
	logic [RAD_W-1:0]        rad_x_q, rad_y_q;
	logic [VAL_W-1:0]        val_q;
	logic [7:0]              sq_a_q, sq_b_q;
	logic signed [POS_W-1:0] x1_q;
	logic [CNT_W-1:0]        y1_q;
	logic signed [ACC_W-1:0] err_q, inc_x_q, inc_y_q;
	logic [CNT_W-1:0]        n_q;
	result_t                 out_q;

	logic [RAD_W-1:0]        rad_x_sat, rad_y_sat;
	logic [11:0]             prod;
	logic signed [ACC_W-1:0] inc_x_init, inc_y_init, err_init;
	logic signed [ACC_W:0]   e2;
	logic                    x_step, y_step;
	logic signed [ACC_W-1:0] two_sq_a, two_sq_b;
	logic signed [ACC_W-1:0] inc_x_n, inc_y_n, err_mid, err_n;
	logic signed [POS_W-1:0] x1_n;
	logic [CNT_W-1:0]        y1_n, y1_tip, n_n;
	logic                    room;
	logic [PT_W-1:0]         cx8, cy8, x8, y8, yt8;
	result_t                 res_main, res_tip;

	// radius saturation
	assign rad_x_sat = (cmd_data.radius_x > RAD_MAX) ? RAD_MAX : cmd_data.radius_x;
	assign rad_y_sat = (cmd_data.radius_y > RAD_MAX) ? RAD_MAX : cmd_data.radius_y;

	// initial increments from the registered squares
	always_comb begin
		prod       = {8'b0, rad_x_q} * {4'b0, sq_b_q};
		inc_x_init = $signed({16'b0, sq_b_q}) - $signed({11'b0, prod, 1'b0});
		inc_y_init = $signed({16'b0, sq_a_q});
		err_init   = inc_x_init + inc_y_init;
	end

	// one error-term step
	always_comb begin
		two_sq_a = $signed({15'b0, sq_a_q, 1'b0});
		two_sq_b = $signed({15'b0, sq_b_q, 1'b0});
		e2       = {err_q, 1'b0};
		x_step   = e2 >= $signed({inc_x_q[ACC_W-1], inc_x_q});
		y_step   = e2 <= $signed({inc_y_q[ACC_W-1], inc_y_q});
		inc_x_n  = x_step ? inc_x_q + two_sq_b : inc_x_q;
		err_mid  = x_step ? err_q + inc_x_n : err_q;
		inc_y_n  = y_step ? inc_y_q + two_sq_a : inc_y_q;
		err_n    = y_step ? err_mid + inc_y_n : err_mid;
		x1_n     = x1_q + $signed({{(POS_W-1){1'b0}}, x_step});
		y1_n     = y1_q + {{(CNT_W-1){1'b0}}, y_step};
		y1_tip   = y1_q + CNT_W'(1);
		n_n      = n_q + CNT_W'(1);
	end

	// loop status for the controller
	always_comb begin
		room                  = n_n < CNT_MAX;
		status.main_more      = (x1_n <= 0) && room;
		status.tip_after_main = (y1_n < {2'b0, rad_y_q}) && room;
		status.tip_more       = (y1_tip < {2'b0, rad_y_q}) && room;
	end

	// mirrored points
	always_comb begin
		cx8 = {2'b0, cx_q};
		cy8 = {2'b0, cy_q};
		x8  = {{(PT_W-POS_W){x1_q[POS_W-1]}}, x1_q};
		y8  = {{(PT_W-CNT_W){1'b0}}, y1_q};
		yt8 = {{(PT_W-CNT_W){1'b0}}, y1_tip};

		res_main.px0         = cx8 - x8;
		res_main.py0         = cy8 + y8;
		res_main.px1         = cx8 + x8;
		res_main.py1         = cy8 + y8;
		res_main.px2         = cx8 + x8;
		res_main.py2         = cy8 - y8;
		res_main.px3         = cx8 - x8;
		res_main.py3         = cy8 - y8;
		res_main.point_mask  = MASK_MAIN;
		res_main.point_value = val_q;
		res_main.last        = ctl.last;

		res_tip.px0         = cx8;
		res_tip.py0         = cy8 + yt8;
		res_tip.px1         = cx8;
		res_tip.py1         = cy8 - yt8;
		res_tip.px2         = '0;
		res_tip.py2         = '0;
		res_tip.px3         = '0;
		res_tip.py3         = '0;
		res_tip.point_mask  = MASK_TIP;
		res_tip.point_value = val_q;
		res_tip.last        = ctl.last;
	end

	// walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q    <= '0;
			cy_q    <= '0;
			rad_x_q <= '0;
			rad_y_q <= '0;
			val_q   <= '0;
			sq_a_q  <= '0;
			sq_b_q  <= '0;
			x1_q    <= '0;
			y1_q    <= '0;
			err_q   <= '0;
			inc_x_q <= '0;
			inc_y_q <= '0;
			n_q     <= '0;
		end else begin
			if (ctl.load) begin
				cx_q    <= cmd_data.center_x;
				cy_q    <= cmd_data.center_y;
				rad_x_q <= rad_x_sat;
				rad_y_q <= rad_y_sat;
				val_q   <= cmd_data.pixel_value;
			end
			if (ctl.square) begin
				sq_a_q <= {4'b0, rad_x_q} * {4'b0, rad_x_q};
				sq_b_q <= {4'b0, rad_y_q} * {4'b0, rad_y_q};
			end
			if (ctl.init) begin
				x1_q    <= -$signed({2'b0, rad_x_q});
				y1_q    <= '0;
				inc_x_q <= inc_x_init;
				inc_y_q <= inc_y_init;
				err_q   <= err_init;
				n_q     <= '0;
			end
			if (ctl.step_main) begin
				x1_q    <= x1_n;
				y1_q    <= y1_n;
				inc_x_q <= inc_x_n;
				inc_y_q <= inc_y_n;
				err_q   <= err_n;
				n_q     <= n_n;
			end
			if (ctl.step_tip) begin
				y1_q <= y1_tip;
				n_q  <= n_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (ctl.step_main) begin
			out_q <= res_main;
		end else if (ctl.step_tip) begin
			out_q <= res_tip;
		end
	end

	assign out_data = out_q;

endmodule

### design/eor_ctrl.sv
// controller: command sequencing and output valid
module eor_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  eor_pkg::dp_status_t status,
	output eor_pkg::dp_cmd_t    ctl
);
	import eor_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   can_emit;
	logic   emit;

	assign can_emit = !out_valid_q || out_ready;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctl.square = 1'b1;
				state_d    = ST_INIT;
			end
			ST_INIT: begin
				ctl.init = 1'b1;
				state_d  = ST_MAIN;
			end
			ST_MAIN: begin
				if (can_emit) begin
					ctl.step_main = 1'b1;
					if (status.main_more) begin
						state_d = ST_MAIN;
					end else if (status.tip_after_main) begin
						state_d = ST_TIP;
					end else begin
						ctl.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_TIP: begin
				if (can_emit) begin
					ctl.step_tip = 1'b1;
					if (!status.tip_more) begin
						ctl.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output valid tracks the output register
	always_comb begin
		emit = ctl.step_main || ctl.step_tip;
		if (emit) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

	// a command transaction starts the setup sequence
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (state_q == ST_LOAD))
		else $error("command accepted without entering load");

	// squares are followed by the increment setup
	a_load_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |=> (state_q == ST_INIT))
		else $error("load not followed by init");

	// a step never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.step_main || ctl.step_tip) |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transaction");

	// the last result returns the controller to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.last |=> (state_q == ST_IDLE))
		else $error("last result did not end the command");

endmodule

### design/ellipse_outline_rasterizer.sv
// top level of the ellipse outline rasterizer
//
//  channel | direction | payload                                       | handshake
//  cmd     | in        | center_x, center_y, radius_x, radius_y, value | valid/ready
//  pt      | out       | px0..py3, point_mask, point_value, last       | valid/ready
//
// A command runs setup steps (capture, squares, increments) and then point groups,
// one group per cycle unless pt stalls, at most 47, set by the single error-term
// step unit. A new command is taken only when the controller is idle; the last
// point group may still wait in the output register then.
// Reset is asynchronous and active low and returns the controller to idle.
// A stall on pt holds the walk with the pending group in the output register.
module ellipse_outline_rasterizer (
	input  logic      clk,
	input  logic      arst_n,
	eor_cmd_if.sink   cmd,
	eor_pt_if.source  pt
);
	import eor_pkg::*;

	dp_cmd_t    ctl;
	dp_status_t status;

	eor_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.out_ready (pt.ready),
		.out_valid (pt.valid),
		.status    (status),
		.ctl       (ctl)
	);

	eor_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_data (cmd.data),
		.ctl      (ctl),
		.status   (status),
		.out_data (pt.data)
	);

endmodule
